// ===== src/ppt_pkg.sv =====
// Shared types, constants and the arctangent table of the planar pose transform.
// No dependencies; every other file refers to it by scoped names.
package ppt_pkg;

   localparam int POS_WIDTH_DEF     = 32;
   localparam int ANGLE_WIDTH_DEF   = 24;
   localparam int CORDIC_STAGES_DEF = 20;

   // fixed-point layout of the datapath
   localparam int ANG_INT_BITS = 4;
   localparam int WORK_FRAC    = 32;
   localparam int GUARD_BITS   = 8;
   localparam int POS_EXTRA    = 12;   // diff bit, guard bits, negate and CORDIC growth
   localparam int Z_WIDTH      = 38;

   // gain correction K in Q31, rounding point after dropping guard bits
   localparam int          GAIN_FRAC  = 31;
   localparam int          GAIN_W     = 31;
   localparam logic [30:0] GAIN_K     = 31'd1304065748;
   localparam int          GAIN_SHIFT = GAIN_FRAC + GUARD_BITS;
   localparam int          ROUND_BIT  = GAIN_SHIFT - 1;
   localparam int          GAIN_LAT   = 5;

   typedef logic signed [Z_WIDTH-1:0] angle_type;

   localparam angle_type HALF_PI = 38'sd6746518852;
   localparam angle_type PI_Q    = 38'sd13493037705;
   localparam angle_type TWO_PI  = 38'sd26986075409;

   typedef enum logic [1:0] {
      OP_TO_WORLD = 2'd0,
      OP_COMPOSE  = 2'd1,
      OP_RELATIVE = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   // atan(2^-idx) with 32 fraction bits
   function automatic angle_type atan_const(input int idx);
      angle_type value;
      case (idx)
         0:  value = 38'sd3373259426;
         1:  value = 38'sd1991351318;
         2:  value = 38'sd1052175346;
         3:  value = 38'sd534100635;
         4:  value = 38'sd268086748;
         5:  value = 38'sd134174063;
         6:  value = 38'sd67103403;
         7:  value = 38'sd33553749;
         8:  value = 38'sd16777131;
         9:  value = 38'sd8388597;
         10: value = 38'sd4194303;
         default: value = angle_type'(64'sd1 <<< (WORK_FRAC - idx));
      endcase
      return value;
   endfunction

endpackage

// ===== src/planar_pose_transform_top.sv =====
// Top level of the planar pose transform: front end, CORDIC cell chain, two
// gain lanes. Depends on ppt_pkg, ppt_prep, ppt_cordic_cell and ppt_gain.
//
// Usage:
//   A transfer on the request side happens at a rising edge with start high
//   and busy low. busy is always low: the block takes a new request every
//   cycle. Each request carries an opcode, a base pose and a second pose or
//   point; opcode 3 returns zeros.
//   Exactly one response per request, in request order. It stays on the rsp_
//   ports for one cycle, marked by rsp_valid; the receiver cannot stall, so
//   the response is taken in that cycle and nothing is held back.
//   Path: the front-end registers for operand selection, 2pi wrap and
//   half-turn fold, a register in each CORDIC cell, then the gain lane
//   stages (abs, split 32-bit-class multiply, round, sign, offset and clip).
//   Throughput: one request per cycle, set by the fully pipelined cell chain.
//   Reset (synchronous, active high) clears every valid bit in the pipe;
//   requests in flight are dropped and no response appears until new ones
//   arrive.
module planar_pose_transform_top #(
   parameter int POS_WIDTH     = ppt_pkg::POS_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = ppt_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = ppt_pkg::CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic signed [POS_WIDTH-1:0]   req_base_x,
   input  logic signed [POS_WIDTH-1:0]   req_base_y,
   input  logic signed [ANGLE_WIDTH-1:0] req_base_theta,
   input  logic signed [POS_WIDTH-1:0]   req_other_x,
   input  logic signed [POS_WIDTH-1:0]   req_other_y,
   input  logic signed [ANGLE_WIDTH-1:0] req_other_theta,
   output logic                          rsp_valid,
   output logic signed [POS_WIDTH-1:0]   rsp_res_x,
   output logic signed [POS_WIDTH-1:0]   rsp_res_y,
   output logic signed [ANGLE_WIDTH-1:0] rsp_res_theta,
   output logic                          rsp_saturated
);

   localparam int XW     = POS_WIDTH + ppt_pkg::POS_EXTRA;
   localparam int SIDE_W = 2 * POS_WIDTH + ANGLE_WIDTH + 2;
   localparam int LAT    = ppt_pkg::GAIN_LAT;

   logic                          pre_valid;
   logic signed [XW-1:0]          pre_x, pre_y;
   ppt_pkg::angle_type            pre_z;
   logic                          pre_add;
   logic signed [POS_WIDTH-1:0]   pre_bx, pre_by;
   logic signed [ANGLE_WIDTH-1:0] pre_theta;
   logic                          pre_tclip;

   logic                          chain_valid [CORDIC_STAGES+1];
   logic signed [XW-1:0]          chain_x     [CORDIC_STAGES+1];
   logic signed [XW-1:0]          chain_y     [CORDIC_STAGES+1];
   ppt_pkg::angle_type            chain_z     [CORDIC_STAGES+1];
   logic [SIDE_W-1:0]             chain_side  [CORDIC_STAGES+1];

   logic                          end_add;
   logic signed [POS_WIDTH-1:0]   end_bx, end_by;
   logic signed [ANGLE_WIDTH-1:0] end_theta;
   logic                          end_tclip;

   logic                          tail_valid_ff [LAT];
   logic signed [ANGLE_WIDTH-1:0] tail_theta_ff [LAT];
   logic                          tail_clip_ff  [LAT];

   logic                          x_clip, y_clip;

   assign busy = 1'b0;

   ppt_prep #(
      .POS_WIDTH   (POS_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_prep (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start && !busy),
      .opcode         (req_opcode),
      .base_x         (req_base_x),
      .base_y         (req_base_y),
      .base_theta     (req_base_theta),
      .other_x        (req_other_x),
      .other_y        (req_other_y),
      .other_theta    (req_other_theta),
      .out_valid      (pre_valid),
      .out_x          (pre_x),
      .out_y          (pre_y),
      .out_z          (pre_z),
      .out_add_base   (pre_add),
      .out_base_x     (pre_bx),
      .out_base_y     (pre_by),
      .out_theta      (pre_theta),
      .out_theta_clip (pre_tclip)
   );

   assign chain_valid[0] = pre_valid;
   assign chain_x[0]     = pre_x;
   assign chain_y[0]     = pre_y;
   assign chain_z[0]     = pre_z;
   assign chain_side[0]  = {pre_add, pre_bx, pre_by, pre_theta, pre_tclip};

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      ppt_cordic_cell #(
         .XW     (XW),
         .SIDE_W (SIDE_W),
         .STEP   (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_x      (chain_x[i]),
         .in_y      (chain_y[i]),
         .in_z      (chain_z[i]),
         .in_side   (chain_side[i]),
         .out_valid (chain_valid[i+1]),
         .out_x     (chain_x[i+1]),
         .out_y     (chain_y[i+1]),
         .out_z     (chain_z[i+1]),
         .out_side  (chain_side[i+1])
      );
   end

   // remaining angle at the end of the chain is not needed
   assign {end_add, end_bx, end_by, end_theta, end_tclip} = chain_side[CORDIC_STAGES];

   ppt_gain #(
      .POS_WIDTH (POS_WIDTH)
   ) u_gain_x (
      .clock    (clock),
      .in_v     (chain_x[CORDIC_STAGES]),
      .in_base  (end_bx),
      .in_add   (end_add),
      .out_res  (rsp_res_x),
      .out_clip (x_clip)
   );

   ppt_gain #(
      .POS_WIDTH (POS_WIDTH)
   ) u_gain_y (
      .clock    (clock),
      .in_v     (chain_y[CORDIC_STAGES]),
      .in_base  (end_by),
      .in_add   (end_add),
      .out_res  (rsp_res_y),
      .out_clip (y_clip)
   );

   // heading and valid ride alongside the gain lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            tail_valid_ff[k] <= 1'b0;
         end
      end else begin
         tail_valid_ff[0] <= chain_valid[CORDIC_STAGES];
         for (int k = 1; k < LAT; k++) begin
            tail_valid_ff[k] <= tail_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      tail_theta_ff[0] <= end_theta;
      tail_clip_ff[0]  <= end_tclip;
      for (int k = 1; k < LAT; k++) begin
         tail_theta_ff[k] <= tail_theta_ff[k-1];
         tail_clip_ff[k]  <= tail_clip_ff[k-1];
      end
   end

   assign rsp_valid     = tail_valid_ff[LAT-1];
   assign rsp_res_theta = tail_theta_ff[LAT-1];
   assign rsp_saturated = tail_clip_ff[LAT-1] | x_clip | y_clip;

endmodule

// ===== src/ppt_prep.sv =====
// Front end of the pose transform: operand selection, heading result and
// rotation angle reduction into [-pi/2, pi/2]. Uses ppt_pkg.
module ppt_prep #(
   parameter int POS_WIDTH   = ppt_pkg::POS_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ppt_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [1:0]                                    opcode,
   input  logic signed [POS_WIDTH-1:0]                   base_x,
   input  logic signed [POS_WIDTH-1:0]                   base_y,
   input  logic signed [ANGLE_WIDTH-1:0]                 base_theta,
   input  logic signed [POS_WIDTH-1:0]                   other_x,
   input  logic signed [POS_WIDTH-1:0]                   other_y,
   input  logic signed [ANGLE_WIDTH-1:0]                 other_theta,
   output logic                                          out_valid,
   output logic signed [POS_WIDTH+ppt_pkg::POS_EXTRA-1:0] out_x,
   output logic signed [POS_WIDTH+ppt_pkg::POS_EXTRA-1:0] out_y,
   output ppt_pkg::angle_type                            out_z,
   output logic                                          out_add_base,
   output logic signed [POS_WIDTH-1:0]                   out_base_x,
   output logic signed [POS_WIDTH-1:0]                   out_base_y,
   output logic signed [ANGLE_WIDTH-1:0]                 out_theta,
   output logic                                          out_theta_clip
);

   localparam int XW        = POS_WIDTH + ppt_pkg::POS_EXTRA;
   localparam int ANG_SHIFT = ppt_pkg::WORK_FRAC - (ANGLE_WIDTH - ppt_pkg::ANG_INT_BITS);

   ppt_pkg::opcode_type op;
   ppt_pkg::angle_type  bt_scaled;
   logic signed [ANGLE_WIDTH:0] tsum;
   logic                        tovf;

   // stage 1
   logic                          valid1_ff, valid1_in;
   logic signed [POS_WIDTH:0]     vx1_ff, vx1_in, vy1_ff, vy1_in;
   ppt_pkg::angle_type            z1_ff, z1_in;
   logic                          add1_ff, add1_in;
   logic signed [POS_WIDTH-1:0]   bx1_ff, by1_ff;
   logic signed [ANGLE_WIDTH-1:0] th1_ff, th1_in;
   logic                          tc1_ff, tc1_in;
   // stage 2
   logic                          valid2_ff;
   logic signed [POS_WIDTH:0]     vx2_ff, vy2_ff;
   ppt_pkg::angle_type            z2_ff, z2_in;
   logic                          add2_ff;
   logic signed [POS_WIDTH-1:0]   bx2_ff, by2_ff;
   logic signed [ANGLE_WIDTH-1:0] th2_ff;
   logic                          tc2_ff;
   // stage 3
   logic                          valid3_ff;
   logic signed [XW-1:0]          x3_ff, x3_in, y3_ff, y3_in;
   ppt_pkg::angle_type            z3_ff, z3_in;
   logic                          add3_ff;
   logic signed [POS_WIDTH-1:0]   bx3_ff, by3_ff;
   logic signed [ANGLE_WIDTH-1:0] th3_ff;
   logic                          tc3_ff;
   logic signed [XW-1:0]          vx_ext, vy_ext;
   logic                          fold;

   assign op        = ppt_pkg::opcode_type'(opcode);
   assign bt_scaled = ppt_pkg::angle_type'(base_theta) <<< ANG_SHIFT;
   assign valid1_in = in_valid;

   always_comb begin
      vx1_in = '0;
      vy1_in = '0;
      z1_in  = '0;
      add1_in = 1'b0;
      tsum   = '0;
      case (op)
         ppt_pkg::OP_TO_WORLD, ppt_pkg::OP_COMPOSE: begin
            vx1_in  = (POS_WIDTH+1)'(other_x);
            vy1_in  = (POS_WIDTH+1)'(other_y);
            z1_in   = bt_scaled;
            add1_in = 1'b1;
            tsum    = (ANGLE_WIDTH+1)'(base_theta) + (ANGLE_WIDTH+1)'(other_theta);
         end
         ppt_pkg::OP_RELATIVE: begin
            vx1_in = (POS_WIDTH+1)'(other_x) - (POS_WIDTH+1)'(base_x);
            vy1_in = (POS_WIDTH+1)'(other_y) - (POS_WIDTH+1)'(base_y);
            z1_in  = -bt_scaled;
            tsum   = (ANGLE_WIDTH+1)'(other_theta) - (ANGLE_WIDTH+1)'(base_theta);
         end
         default: begin
         end
      endcase
   end

   // heading: kept for point mapping, clipped sum or difference, else 0
   always_comb begin
      tovf = tsum[ANGLE_WIDTH] ^ tsum[ANGLE_WIDTH-1];
      case (op)
         ppt_pkg::OP_TO_WORLD: begin
            th1_in = other_theta;
            tc1_in = 1'b0;
         end
         ppt_pkg::OP_COMPOSE, ppt_pkg::OP_RELATIVE: begin
            th1_in = tovf ? {tsum[ANGLE_WIDTH], {(ANGLE_WIDTH-1){~tsum[ANGLE_WIDTH]}}}
                          : tsum[ANGLE_WIDTH-1:0];
            tc1_in = tovf;
         end
         default: begin
            th1_in = '0;
            tc1_in = 1'b0;
         end
      endcase
   end

   // one wrap by 2pi is enough: |z| never exceeds 8 rad
   always_comb begin
      if (z1_ff > ppt_pkg::PI_Q) begin
         z2_in = z1_ff - ppt_pkg::TWO_PI;
      end else if (z1_ff < -ppt_pkg::PI_Q) begin
         z2_in = z1_ff + ppt_pkg::TWO_PI;
      end else begin
         z2_in = z1_ff;
      end
   end

   // fold into the right half plane by pi, negating the vector
   always_comb begin
      vx_ext = XW'(vx2_ff);
      vy_ext = XW'(vy2_ff);
      fold   = 1'b1;
      if (z2_ff > ppt_pkg::HALF_PI) begin
         z3_in = z2_ff - ppt_pkg::PI_Q;
      end else if (z2_ff < -ppt_pkg::HALF_PI) begin
         z3_in = z2_ff + ppt_pkg::PI_Q;
      end else begin
         z3_in = z2_ff;
         fold  = 1'b0;
      end
      x3_in = (fold ? -vx_ext : vx_ext) <<< ppt_pkg::GUARD_BITS;
      y3_in = (fold ? -vy_ext : vy_ext) <<< ppt_pkg::GUARD_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      vx1_ff  <= vx1_in;
      vy1_ff  <= vy1_in;
      z1_ff   <= z1_in;
      add1_ff <= add1_in;
      bx1_ff  <= base_x;
      by1_ff  <= base_y;
      th1_ff  <= th1_in;
      tc1_ff  <= tc1_in;

      vx2_ff  <= vx1_ff;
      vy2_ff  <= vy1_ff;
      z2_ff   <= z2_in;
      add2_ff <= add1_ff;
      bx2_ff  <= bx1_ff;
      by2_ff  <= by1_ff;
      th2_ff  <= th1_ff;
      tc2_ff  <= tc1_ff;

      x3_ff   <= x3_in;
      y3_ff   <= y3_in;
      z3_ff   <= z3_in;
      add3_ff <= add2_ff;
      bx3_ff  <= bx2_ff;
      by3_ff  <= by2_ff;
      th3_ff  <= th2_ff;
      tc3_ff  <= tc2_ff;
   end

   assign out_valid      = valid3_ff;
   assign out_x          = x3_ff;
   assign out_y          = y3_ff;
   assign out_z          = z3_ff;
   assign out_add_base   = add3_ff;
   assign out_base_x     = bx3_ff;
   assign out_base_y     = by3_ff;
   assign out_theta      = th3_ff;
   assign out_theta_clip = tc3_ff;

endmodule

// ===== src/ppt_cordic_cell.sv =====
// One CORDIC rotation cell: a fixed shift and arctangent step, registered.
// Uses ppt_pkg for the angle type and the arctangent table.
module ppt_cordic_cell #(
   parameter int XW     = ppt_pkg::POS_WIDTH_DEF + ppt_pkg::POS_EXTRA,
   parameter int SIDE_W = 1,
   parameter int STEP   = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [XW-1:0]     in_x,
   input  logic signed [XW-1:0]     in_y,
   input  ppt_pkg::angle_type       in_z,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [XW-1:0]     out_x,
   output logic signed [XW-1:0]     out_y,
   output ppt_pkg::angle_type       out_z,
   output logic [SIDE_W-1:0]        out_side
);

   localparam ppt_pkg::angle_type ATAN = ppt_pkg::atan_const(STEP);

   logic                 valid_ff;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   ppt_pkg::angle_type   z_ff, z_in;
   logic [SIDE_W-1:0]    side_ff;
   logic signed [XW-1:0] dx, dy;

   assign dx = in_y >>> STEP;
   assign dy = in_x >>> STEP;

   always_comb begin
      if (!in_z[ppt_pkg::Z_WIDTH-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

// ===== src/ppt_gain.sv =====
// One output lane: CORDIC gain correction, rounding, base offset and clipping.
// Five register stages; uses ppt_pkg for the gain constant and layout.
module ppt_gain #(
   parameter int POS_WIDTH = ppt_pkg::POS_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic signed [POS_WIDTH+ppt_pkg::POS_EXTRA-1:0] in_v,
   input  logic signed [POS_WIDTH-1:0]                   in_base,
   input  logic                                          in_add,
   output logic signed [POS_WIDTH-1:0]                   out_res,
   output logic                                          out_clip
);

   localparam int MW  = POS_WIDTH + ppt_pkg::POS_EXTRA;
   localparam int LO  = MW / 2;
   localparam int HI  = MW - LO;
   localparam int AW  = MW + ppt_pkg::GAIN_W + 1;
   localparam int RW  = AW - ppt_pkg::GAIN_SHIFT;
   localparam int OW  = RW + 1;
   localparam int SW  = OW + 1;

   // stage 1: magnitude
   logic                            neg1_ff;
   logic [MW-1:0]                   mag1_ff, mag1_in;
   logic signed [POS_WIDTH-1:0]     base1_ff;
   logic                            add1_ff;
   // stage 2: partial products
   logic                            neg2_ff;
   logic [LO+ppt_pkg::GAIN_W-1:0]   plo2_ff, plo2_in;
   logic [HI+ppt_pkg::GAIN_W-1:0]   phi2_ff, phi2_in;
   logic signed [POS_WIDTH-1:0]     base2_ff;
   logic                            add2_ff;
   // stage 3: rounded magnitude
   logic                            neg3_ff;
   logic [RW-1:0]                   r3_ff;
   logic [AW-1:0]                   acc;
   logic signed [POS_WIDTH-1:0]     base3_ff;
   logic                            add3_ff;
   // stage 4: signed value
   logic signed [OW-1:0]            s4_ff, s4_in, r_signed;
   logic signed [POS_WIDTH-1:0]     base4_ff;
   logic                            add4_ff;
   // stage 5: offset and clip
   logic signed [SW-1:0]            sum;
   logic [SW-POS_WIDTH:0]           upper;
   logic                            ovf;
   logic signed [POS_WIDTH-1:0]     res5_ff, res5_in;
   logic                            clip5_ff;

   assign mag1_in = in_v[MW-1] ? MW'(-in_v) : MW'(in_v);

   assign plo2_in = (LO+ppt_pkg::GAIN_W)'(mag1_ff[LO-1:0]) *
                    (LO+ppt_pkg::GAIN_W)'(ppt_pkg::GAIN_K);
   assign phi2_in = (HI+ppt_pkg::GAIN_W)'(mag1_ff[MW-1:LO]) *
                    (HI+ppt_pkg::GAIN_W)'(ppt_pkg::GAIN_K);

   // round half away from zero on the magnitude
   assign acc = (AW'(phi2_ff) << LO) + AW'(plo2_ff) + (AW'(1) << ppt_pkg::ROUND_BIT);

   assign r_signed = $signed({1'b0, r3_ff});
   assign s4_in    = neg3_ff ? -r_signed : r_signed;

   always_comb begin
      sum   = SW'(s4_ff) + (add4_ff ? SW'(base4_ff) : SW'(0));
      upper = sum[SW-1:POS_WIDTH-1];
      ovf   = !((&upper) || !(|upper));
      res5_in = ovf ? {sum[SW-1], {(POS_WIDTH-1){~sum[SW-1]}}} : sum[POS_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      neg1_ff  <= in_v[MW-1];
      mag1_ff  <= mag1_in;
      base1_ff <= in_base;
      add1_ff  <= in_add;

      neg2_ff  <= neg1_ff;
      plo2_ff  <= plo2_in;
      phi2_ff  <= phi2_in;
      base2_ff <= base1_ff;
      add2_ff  <= add1_ff;

      neg3_ff  <= neg2_ff;
      r3_ff    <= acc[AW-1:ppt_pkg::GAIN_SHIFT];
      base3_ff <= base2_ff;
      add3_ff  <= add2_ff;

      s4_ff    <= s4_in;
      base4_ff <= base3_ff;
      add4_ff  <= add3_ff;

      res5_ff  <= res5_in;
      clip5_ff <= ovf;
   end

   assign out_res  = res5_ff;
   assign out_clip = clip5_ff;

endmodule

// ===== test/tb.sv =====
// Testbench for planar_pose_transform_top: directed and random SE(2) requests
// against a bit-exact CORDIC pose predictor. Depends on ppt_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

   localparam int POS_W       = ppt_pkg::POS_WIDTH_DEF;
   localparam int ANG_W       = ppt_pkg::ANGLE_WIDTH_DEF;
   localparam int STAGES      = ppt_pkg::CORDIC_STAGES_DEF;
   localparam int ROT_STAGES  = STAGES > 32 ? 32 : STAGES;
   localparam int LATENCY     = 3 + STAGES + 5;
   localparam int STALL_LIMIT = 20 * (LATENCY + 11);

   localparam logic signed [POS_W-1:0] P_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] P_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [POS_W-1:0] ONE_M = 1 <<< (POS_W - 16);
   localparam logic signed [ANG_W-1:0] A_MAX = {1'b0, {(ANG_W-1){1'b1}}};
   localparam logic signed [ANG_W-1:0] A_MIN = {1'b1, {(ANG_W-1){1'b0}}};
   localparam logic signed [ANG_W-1:0] PI_A  = 24'sd3294199;   // pi in Q4.20
   localparam logic signed [ANG_W-1:0] HPI_A = 24'sd1647099;   // pi/2 in Q4.20
   localparam logic signed [ANG_W-1:0] A_ONE = 24'sd1;

   typedef struct {
      ppt_pkg::opcode_type      op;
      logic signed [POS_W-1:0]  base_x;
      logic signed [POS_W-1:0]  base_y;
      logic signed [ANG_W-1:0]  base_theta;
      logic signed [POS_W-1:0]  other_x;
      logic signed [POS_W-1:0]  other_y;
      logic signed [ANG_W-1:0]  other_theta;
   } pose_req_type;

   typedef struct {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic signed [ANG_W-1:0]  theta;
      logic                     clipped;
   } pose_res_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_opcode = '0;
   logic signed [POS_W-1:0]  req_base_x = '0;
   logic signed [POS_W-1:0]  req_base_y = '0;
   logic signed [ANG_W-1:0]  req_base_theta = '0;
   logic signed [POS_W-1:0]  req_other_x = '0;
   logic signed [POS_W-1:0]  req_other_y = '0;
   logic signed [ANG_W-1:0]  req_other_theta = '0;
   logic                     rsp_valid;
   logic signed [POS_W-1:0]  rsp_res_x;
   logic signed [POS_W-1:0]  rsp_res_y;
   logic signed [ANG_W-1:0]  rsp_res_theta;
   logic                     rsp_saturated;

   pose_res_type expected_poses[$];
   int           mismatches = 0;
   int           quiet_cycles = 0;
   bit           allow_gaps = 1'b1;

   // angle constants, 32 fraction bits
   longint    atan_q32[32];
   longint    half_pi_q32, pi_q32, two_pi_q32;

   planar_pose_transform_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_base_x      (req_base_x),
      .req_base_y      (req_base_y),
      .req_base_theta  (req_base_theta),
      .req_other_x     (req_other_x),
      .req_other_y     (req_other_y),
      .req_other_theta (req_other_theta),
      .rsp_valid       (rsp_valid),
      .rsp_res_x       (rsp_res_x),
      .rsp_res_y       (rsp_res_y),
      .rsp_res_theta   (rsp_res_theta),
      .rsp_saturated   (rsp_saturated)
   );

   always #5 clock = ~clock;

   // atan(1/n) in Q60 by the alternating series, each term truncated
   function automatic longint unsigned atan_recip_q60(longint unsigned n);
      longint unsigned t, nn, sum, term;
      int k;
      t = (64'd1 << 60) / n;
      nn = n * n;
      sum = 0;
      k = 0;
      while (t != 0) begin
         term = t / longint'(2 * k + 1);
         if (k[0]) sum = sum - term;
         else sum = sum + term;
         t = t / nn;
         k++;
      end
      return sum;
   endfunction

   function automatic longint q60_to_q32(longint unsigned v);
      return longint'((v + (64'd1 << 27)) >> 28);
   endfunction

   initial begin
      longint unsigned quarter_pi;
      quarter_pi = atan_recip_q60(2) + atan_recip_q60(3);
      atan_q32[0] = q60_to_q32(quarter_pi);
      for (int i = 1; i < 32; i++)
         atan_q32[i] = q60_to_q32(atan_recip_q60(64'd1 << i));
      half_pi_q32 = q60_to_q32(2 * quarter_pi);
      pi_q32      = q60_to_q32(4 * quarter_pi);
      two_pi_q32  = q60_to_q32(8 * quarter_pi);
   end

   // times K, drop guard bits, round magnitude half up
   function automatic longint gain_round(longint v);
      logic [95:0] mag;
      bit neg;
      neg = v < 0;
      mag = neg ? -v : v;
      mag = (mag * 96'd1304065748 + (96'd1 << (ppt_pkg::GUARD_BITS + 30)))
            >> (ppt_pkg::GUARD_BITS + 31);
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic longint clamp_signed(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic pose_res_type transform_pose(pose_req_type r);
      pose_res_type res;
      longint bx, by, bt, ox, oy, ot, vx, vy, z, dx, dy, sx, sy, st, cx, cy, ct;
      bx = r.base_x;
      by = r.base_y;
      bt = r.base_theta;
      ox = r.other_x;
      oy = r.other_y;
      ot = r.other_theta;
      res.x = '0;
      res.y = '0;
      res.theta = '0;
      res.clipped = 1'b0;
      if (r.op == ppt_pkg::OP_NONE) return res;
      if (r.op == ppt_pkg::OP_RELATIVE) begin
         vx = ox - bx;
         vy = oy - by;
         z = -bt <<< (ppt_pkg::WORK_FRAC - (ANG_W - ppt_pkg::ANG_INT_BITS));
      end else begin
         vx = ox;
         vy = oy;
         z = bt <<< (ppt_pkg::WORK_FRAC - (ANG_W - ppt_pkg::ANG_INT_BITS));
      end
      vx = vx <<< ppt_pkg::GUARD_BITS;
      vy = vy <<< ppt_pkg::GUARD_BITS;
      repeat (3) begin
         if (z > pi_q32) z = z - two_pi_q32;
         else if (z < -pi_q32) z = z + two_pi_q32;
      end
      // fold into the right half plane by a half turn
      if (z > half_pi_q32) begin
         z = z - pi_q32;
         vx = -vx;
         vy = -vy;
      end else if (z < -half_pi_q32) begin
         z = z + pi_q32;
         vx = -vx;
         vy = -vy;
      end
      for (int i = 0; i < ROT_STAGES; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (z >= 0) begin
            vx = vx - dx;
            vy = vy + dy;
            z = z - atan_q32[i];
         end else begin
            vx = vx + dx;
            vy = vy - dy;
            z = z + atan_q32[i];
         end
      end
      sx = gain_round(vx);
      sy = gain_round(vy);
      if (r.op != ppt_pkg::OP_RELATIVE) begin
         sx = sx + bx;
         sy = sy + by;
      end
      case (r.op)
         ppt_pkg::OP_TO_WORLD: st = ot;
         ppt_pkg::OP_COMPOSE:  st = bt + ot;
         default:              st = ot - bt;
      endcase
      cx = clamp_signed(sx, POS_W);
      cy = clamp_signed(sy, POS_W);
      ct = clamp_signed(st, ANG_W);
      res.x = cx[POS_W-1:0];
      res.y = cy[POS_W-1:0];
      res.theta = ct[ANG_W-1:0];
      res.clipped = (cx != sx) || (cy != sy) || (ct != st);
      return res;
   endfunction

   function automatic pose_req_type pose_req(ppt_pkg::opcode_type op,
                                             logic signed [POS_W-1:0] bx, by,
                                             logic signed [ANG_W-1:0] bt,
                                             logic signed [POS_W-1:0] ox, oy,
                                             logic signed [ANG_W-1:0] ot);
      pose_req_type r;
      r.op = op;
      r.base_x = bx;
      r.base_y = by;
      r.base_theta = bt;
      r.other_x = ox;
      r.other_y = oy;
      r.other_theta = ot;
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] random_pos();
      case ($urandom_range(0, 9))
         0:       return P_MAX;
         1:       return P_MIN;
         2, 3, 4: return POS_W'($signed($urandom) >>> 11);    // within about 16 m
         default: return POS_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [ANG_W-1:0] random_angle();
      int a;
      case ($urandom_range(0, 9))
         0:          return A_MAX;
         1:          return A_MIN;
         2, 3, 4, 5: begin
            a = int'($urandom_range(0, 2 * 3294199)) - 3294199;
            return a[ANG_W-1:0];
         end
         default:    return ANG_W'($urandom);
      endcase
   endfunction

   function automatic pose_req_type random_pose_req();
      int sel;
      sel = $urandom_range(0, 9);
      return pose_req(sel == 9 ? ppt_pkg::OP_NONE : ppt_pkg::opcode_type'(sel % 3),
                      random_pos(), random_pos(), random_angle(),
                      random_pos(), random_pos(), random_angle());
   endfunction

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
         req_opcode = 2'($urandom);
         req_base_x = POS_W'($urandom);
         req_other_y = POS_W'($urandom);
         req_other_theta = ANG_W'($urandom);
      end
   endtask

   // drive one request, hold it until the transfer, then queue its result
   task automatic send_pose(pose_req_type r);
      if (allow_gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 11));
      @(negedge clock);
      start = 1'b1;
      req_opcode = r.op;
      req_base_x = r.base_x;
      req_base_y = r.base_y;
      req_base_theta = r.base_theta;
      req_other_x = r.other_x;
      req_other_y = r.other_y;
      req_other_theta = r.other_theta;
      do @(posedge clock); while (busy);
      expected_poses.insert(expected_poses.size(), transform_pose(r));
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      pose_res_type want;
      if (!reset && rsp_valid) begin
         if (expected_poses.size() == 0) begin
            mismatches++;
            $error("response with no request outstanding");
         end else begin
            want = expected_poses.pop_front();
            check_field("res_x", want.x, rsp_res_x);
            check_field("res_y", want.y, rsp_res_y);
            check_field("res_theta", want.theta, rsp_res_theta);
            check_field("saturated", want.clipped, rsp_saturated);
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic test_rotation_basics();
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, 0, 0, 0, 0, 0, 0));
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, ONE_M, -ONE_M, HPI_A, ONE_M, 0, 24'sd1234));
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, 0, 0, -HPI_A, 0, ONE_M, 0));
      send_pose(pose_req(ppt_pkg::OP_COMPOSE, 32'sd5000000, 32'sd7000, PI_A,
                         -32'sd1, -32'sd1, -HPI_A));
      send_pose(pose_req(ppt_pkg::OP_RELATIVE, 32'sd65536000, -32'sd16384, -PI_A,
                         32'sd6553600, 32'sd131072000, PI_A));
      send_pose(pose_req(ppt_pkg::OP_RELATIVE, -32'sd3, 32'sd7, HPI_A + A_ONE,
                         32'sd11, -32'sd5, HPI_A - A_ONE));
   endtask

   // headings beyond a half turn need the 2pi reduction and the half-turn fold
   task automatic test_angle_wrap();
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, 32'sd1000, 32'sd2000, A_MAX,
                         32'sd65568768, -32'sd131088384, 0));
      send_pose(pose_req(ppt_pkg::OP_COMPOSE, -32'sd1000, 32'sd2000, A_MIN,
                         32'sd65568768, 32'sd131088384, 0));
      send_pose(pose_req(ppt_pkg::OP_RELATIVE, 32'sd123456, -32'sd654321, A_MIN,
                         -32'sd987654, 32'sd456789, 0));
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, 0, 0, PI_A + A_ONE,
                         32'sd3276800, 32'sd1638400, 0));
      send_pose(pose_req(ppt_pkg::OP_COMPOSE, 0, 0, -PI_A - A_ONE,
                         32'sd3276800, -32'sd1638400, 0));
   endtask

   task automatic test_saturation();
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, P_MAX, 0, 0, P_MAX, 0, 0));
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, P_MIN, 0, 0, P_MIN, 0, 0));
      send_pose(pose_req(ppt_pkg::OP_RELATIVE, P_MIN, 0, 0, P_MAX, 0, 0));
      send_pose(pose_req(ppt_pkg::OP_RELATIVE, 0, P_MAX, 0, 0, P_MIN, 0));
      send_pose(pose_req(ppt_pkg::OP_COMPOSE, 0, P_MAX, HPI_A, P_MAX, 0, 0));
      send_pose(pose_req(ppt_pkg::OP_COMPOSE, 0, 0, A_MAX, 0, 0, A_MAX));
      send_pose(pose_req(ppt_pkg::OP_COMPOSE, 0, 0, A_MIN, 0, 0, A_MIN));
      send_pose(pose_req(ppt_pkg::OP_RELATIVE, 0, 0, A_MIN, 0, 0, A_MAX));
   endtask

   // no-op opcode returns zeros; to-world heading passes through unclipped
   task automatic test_no_operation();
      send_pose(pose_req(ppt_pkg::OP_NONE, P_MAX, P_MIN, A_MAX, P_MIN, P_MAX, A_MIN));
      send_pose(pose_req(ppt_pkg::OP_NONE, 0, 0, 0, 0, 0, 0));
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, 0, 0, A_MAX, ONE_M, ONE_M, A_MAX));
      send_pose(pose_req(ppt_pkg::OP_TO_WORLD, 0, 0, A_MIN, ONE_M, ONE_M, A_MIN));
   endtask

   task automatic test_random_poses();
      for (int n = 0; n < 550; n++) begin
         if (n % 40 == 0) allow_gaps = $urandom_range(0, 2) != 0;
         send_pose(random_pose_req());
      end
   endtask

   task automatic test_back_to_back();
      allow_gaps = 1'b0;
      repeat (100) send_pose(random_pose_req());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_rotation_basics();
      test_angle_wrap();
      test_saturation();
      test_no_operation();
      test_random_poses();
      test_back_to_back();
      @(negedge clock);
      start = 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/ppt_pkg.sv
src/ppt_prep.sv
src/ppt_cordic_cell.sv
src/ppt_gain.sv
src/planar_pose_transform_top.sv
test/tb.sv
